>>> hdl/kcc_pkg.sv
// Shared types and constants for the nearest-neighbor color classifier.
package kcc_pkg;

    localparam int CHAN_W  = 12;
    localparam int RAW_W   = 16;
    localparam int DIST_W  = 26;
    localparam int COUNT_W = 7;
    localparam int VOTE_W  = 3;
    localparam int CLASS_W = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 26;
    localparam int QUOT_W  = 12;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 12'd4080;
    localparam logic [DIST_W-1:0] DIST_MAX = 26'h3FFFFFF;

    localparam logic [CFG_IDX_W-1:0] REG_WHITE_RED   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WHITE_GREEN = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WHITE_BLUE  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLACK_RED   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLACK_GREEN = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLACK_BLUE  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DIST_LIMIT  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 4'd7;

    localparam logic FUNC_LOAD     = 1'b0;
    localparam logic FUNC_CLASSIFY = 1'b1;

    localparam logic [CLASS_W-1:0] CLASS_RED     = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_GREEN   = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_NEITHER = 2'd2;

    typedef struct packed {
        logic              label;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } entry_t;

    typedef struct packed {
        logic               valid;
        logic               label;
        logic [COUNT_W-1:0] slot;
        logic [DIST_W-1:0]  distance;
    } cell_t;

    typedef enum logic [1:0] {
        D_IDLE,
        D_MUL,
        D_DIV
    } div_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NORM_START,
        ST_NORM_WAIT,
        ST_WALK,
        ST_DRAIN,
        ST_DONE
    } ctl_state_t;

endpackage

>>> hdl/kcc_if.sv
// Valid/ready channel interfaces for input items and results.
interface kcc_in_if
    import kcc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              func;
    logic [5:0]        entry_index;
    logic              train_label;
    logic [CHAN_W-1:0] train_red;
    logic [CHAN_W-1:0] train_green;
    logic [CHAN_W-1:0] train_blue;
    logic [RAW_W-1:0]  raw_red;
    logic [RAW_W-1:0]  raw_green;
    logic [RAW_W-1:0]  raw_blue;

    modport source (output valid, func, entry_index, train_label, train_red, train_green,
                    train_blue, raw_red, raw_green, raw_blue, input ready);
    modport sink (input valid, func, entry_index, train_label, train_red, train_green,
                  train_blue, raw_red, raw_green, raw_blue, output ready);
endinterface

interface kcc_out_if
    import kcc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CLASS_W-1:0] colour_class;
    logic [DIST_W-1:0]  nearest_distance;
    logic [VOTE_W-1:0]  red_votes;
    logic [VOTE_W-1:0]  green_votes;

    modport source (output valid, colour_class, nearest_distance, red_votes, green_votes,
                    input ready);
    modport sink (input valid, colour_class, nearest_distance, red_votes, green_votes,
                  output ready);
endinterface

>>> hdl/kcc_divider.sv
// Sequential normalizer: (raw-white)*4080/(black-white), clamped to 0..4080.
module kcc_divider
    import kcc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [RAW_W-1:0]  raw,
    input  logic [RAW_W-1:0]  white,
    input  logic [RAW_W-1:0]  black,
    output logic              done,
    output logic [CHAN_W-1:0] value
);

    div_state_t state_reg, state_next;

    logic [RAW_W-1:0]  mag_d_reg;
    logic [RAW_W-1:0]  mag_s_reg;
    logic              zero_reg;
    logic              clamp_reg;
    logic [RAW_W-1:0]  rem_reg;
    logic [QUOT_W-1:0] low_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic [3:0]        cnt_reg;
    logic              done_reg;

    logic [RAW_W:0]    d;
    logic [RAW_W:0]    s;
    logic [RAW_W-1:0]  mag_d;
    logic [RAW_W-1:0]  mag_s;
    logic [27:0]       prod;
    logic [RAW_W:0]    trial;
    logic [RAW_W:0]    diff;
    logic              qbit;

    assign d     = {1'b0, raw} - {1'b0, white};
    assign s     = {1'b0, black} - {1'b0, white};
    assign mag_d = d[RAW_W] ? RAW_W'(-d) : d[RAW_W-1:0];
    assign mag_s = s[RAW_W] ? RAW_W'(-s) : s[RAW_W-1:0];
    assign prod  = 28'(mag_d_reg) * 28'(CHAN_MAX);
    assign trial = {rem_reg, low_reg[QUOT_W-1]};
    assign diff  = trial - {1'b0, mag_s_reg};
    assign qbit  = (trial >= {1'b0, mag_s_reg});

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            D_IDLE:
            begin
                if (start)
                    state_next = D_MUL;
            end
            D_MUL:
                state_next = D_DIV;
            D_DIV:
            begin
                if (cnt_reg == 4'(QUOT_W - 1))
                    state_next = D_IDLE;
            end
            default:
                state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == D_DIV) && (cnt_reg == 4'(QUOT_W - 1));
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            D_IDLE:
            begin
                mag_d_reg <= mag_d;
                mag_s_reg <= mag_s;
                // negative or zero quotients all clamp to zero
                zero_reg  <= (s == '0) || (d == '0) || (d[RAW_W] != s[RAW_W]);
                clamp_reg <= (mag_d >= mag_s);
            end
            D_MUL:
            begin
                // quotient < 4096 here, so the top bits already sit below the divisor
                rem_reg  <= prod[27:QUOT_W];
                low_reg  <= prod[QUOT_W-1:0];
                quot_reg <= '0;
                cnt_reg  <= '0;
            end
            D_DIV:
            begin
                rem_reg  <= qbit ? diff[RAW_W-1:0] : trial[RAW_W-1:0];
                low_reg  <= {low_reg[QUOT_W-2:0], 1'b0};
                quot_reg <= {quot_reg[QUOT_W-2:0], qbit};
                cnt_reg  <= cnt_reg + 4'd1;
            end
            default:
            begin
            end
        endcase
    end

    assign done  = done_reg;
    assign value = zero_reg ? '0 : (clamp_reg ? CHAN_MAX : quot_reg);

endmodule

>>> hdl/kcc_cell.sv
// One insertion cell of the nearest-neighbor sorting chain.
module kcc_cell
    import kcc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  clear,
    input  cell_t cand_in,
    output cell_t cand_out,
    output cell_t held
);

    cell_t held_reg, held_next;
    cell_t pass_reg, pass_next;

    always_comb
    begin
        held_next = held_reg;
        pass_next = cand_in;
        // equal distances go to the lower table index
        if (cand_in.valid && (!held_reg.valid || (cand_in.distance < held_reg.distance) ||
            ((cand_in.distance == held_reg.distance) && (cand_in.slot < held_reg.slot))))
        begin
            held_next = cand_in;
            pass_next = held_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            pass_reg <= '0;
        end
        else if (clear)
        begin
            held_reg.valid <= 1'b0;
            pass_reg.valid <= 1'b0;
        end
        else
        begin
            held_reg <= held_next;
            pass_reg <= pass_next;
        end
    end

    assign cand_out = pass_reg;
    assign held     = held_reg;

endmodule

>>> hdl/knn_color_classifier_core.sv
// Top level of the nearest-neighbor red/green color classifier.
//
// Channels: in_ch carries load and classify beats, out_ch one result per
// classify beat; both are valid/ready. Configuration is a plain write port
// (cfg_we, cfg_index, cfg_data), to be written only while the block is idle;
// the block itself does not enforce this. A load beat writes one table entry
// (if entry_index is below MAX_ENTRIES) and the block stays idle.
// A classify beat normalizes the three channels one after another in a
// shared divider with a 12-bit quotient, then reads the table one entry per
// cycle through a three-stage path into a chain of NEIGHBORS insertion
// cells, then drains the chain; walk and drain are skipped when no entries
// are in use. No new item is taken until the result is loaded.
// The result sits in an output register; if the receiver stalls it holds,
// and the next item is still accepted. A second finished result waits in
// the final state until the register frees up.
// Reset restores the register defaults; the table is not cleared and
// entries below entry_count must be loaded before classifying.
module knn_color_classifier_core
    import kcc_pkg::*;
#(
    parameter int MAX_ENTRIES = 64,
    parameter int NEIGHBORS   = 3
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    kcc_in_if.sink                in_ch,
    kcc_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int DRAIN_LEN = NEIGHBORS + 3;

    ctl_state_t state_reg, state_next;

    logic [RAW_W-1:0]   white_reg [3];
    logic [RAW_W-1:0]   black_reg [3];
    logic [DIST_W-1:0]  limit_reg;
    logic [COUNT_W-1:0] count_reg;

    logic [RAW_W-1:0]   raw_reg [3];
    logic [CHAN_W-1:0]  smp_reg [3];
    logic [1:0]         chan_reg;
    logic [COUNT_W-1:0] n_reg;
    logic [COUNT_W-1:0] walk_reg;
    logic [3:0]         drain_reg;

    entry_t             mem [MAX_ENTRIES];
    entry_t             rd_reg;
    logic               v1_reg, v2_reg, v3_reg;
    logic               lab2_reg, lab3_reg;
    logic [COUNT_W-1:0] slot1_reg, slot2_reg, slot3_reg;
    logic [23:0]        sq_reg [3];
    logic [DIST_W-1:0]  sum_reg;

    logic               out_valid_reg;
    logic [CLASS_W-1:0] class_reg;
    logic [DIST_W-1:0]  dist_reg;
    logic [VOTE_W-1:0]  red_reg, green_reg;

    logic               accept;
    logic               load_out;
    logic               div_start, div_done;
    logic [CHAN_W-1:0]  div_value;
    logic [COUNT_W-1:0] n_eff;
    cell_t              chain [NEIGHBORS+1];
    cell_t              held [NEIGHBORS];
    logic               clear_cells;
    logic [VOTE_W-1:0]  red_cnt, green_cnt;
    logic [DIST_W-1:0]  best;
    logic [CLASS_W-1:0] cls;
    logic signed [CHAN_W:0] diff [3];
    logic [CHAN_W-1:0]  ech [3];

    assign accept   = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || out_ch.ready);
    assign div_start = (state_reg == ST_NORM_START);
    assign clear_cells = accept && (in_ch.func == FUNC_CLASSIFY);
    assign n_eff = (32'(count_reg) > MAX_ENTRIES) ? COUNT_W'(MAX_ENTRIES) : count_reg;

    kcc_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .raw   (raw_reg[chan_reg]),
        .white (white_reg[chan_reg]),
        .black (black_reg[chan_reg]),
        .done  (div_done),
        .value (div_value)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            white_reg[0] <= 16'd121;
            white_reg[1] <= 16'd136;
            white_reg[2] <= 16'd123;
            black_reg[0] <= 16'd929;
            black_reg[1] <= 16'd813;
            black_reg[2] <= 16'd569;
            limit_reg    <= 26'd51200;
            count_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WHITE_RED:   white_reg[0] <= cfg_data[RAW_W-1:0];
                REG_WHITE_GREEN: white_reg[1] <= cfg_data[RAW_W-1:0];
                REG_WHITE_BLUE:  white_reg[2] <= cfg_data[RAW_W-1:0];
                REG_BLACK_RED:   black_reg[0] <= cfg_data[RAW_W-1:0];
                REG_BLACK_GREEN: black_reg[1] <= cfg_data[RAW_W-1:0];
                REG_BLACK_BLUE:  black_reg[2] <= cfg_data[RAW_W-1:0];
                REG_DIST_LIMIT:  limit_reg    <= cfg_data[DIST_W-1:0];
                REG_ENTRY_COUNT: count_reg    <= cfg_data[COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // control
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_ch.func == FUNC_CLASSIFY))
                    state_next = ST_NORM_START;
            end
            ST_NORM_START:
                state_next = ST_NORM_WAIT;
            ST_NORM_WAIT:
            begin
                if (div_done)
                begin
                    if (chan_reg != 2'd2)
                        state_next = ST_NORM_START;
                    else if (n_reg == '0)
                        state_next = ST_DONE;
                    else
                        state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (walk_reg == n_reg - COUNT_W'(1))
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (drain_reg == 4'(DRAIN_LEN - 1))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
            v1_reg <= (state_reg == ST_WALK);
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            raw_reg[0] <= in_ch.raw_red;
            raw_reg[1] <= in_ch.raw_green;
            raw_reg[2] <= in_ch.raw_blue;
            chan_reg   <= '0;
            n_reg      <= n_eff;
        end
        if (state_reg == ST_NORM_WAIT && div_done)
        begin
            smp_reg[chan_reg] <= div_value;
            chan_reg <= chan_reg + 2'd1;
            walk_reg <= '0;
        end
        if (state_reg == ST_WALK)
        begin
            walk_reg <= walk_reg + COUNT_W'(1);
            drain_reg <= '0;
        end
        if (state_reg == ST_DRAIN)
            drain_reg <= drain_reg + 4'd1;
    end

    // table
    always_ff @(posedge clk)
    begin
        if (accept && (in_ch.func == FUNC_LOAD) && (32'(in_ch.entry_index) < MAX_ENTRIES))
            mem[AW'(in_ch.entry_index)] <= {in_ch.train_label, in_ch.train_red,
                                            in_ch.train_green, in_ch.train_blue};
        if (state_reg == ST_WALK)
        begin
            rd_reg    <= mem[AW'(walk_reg)];
            slot1_reg <= walk_reg;
        end
    end

    // distance pipeline: read, square, sum
    assign ech[0] = rd_reg.red;
    assign ech[1] = rd_reg.green;
    assign ech[2] = rd_reg.blue;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
            diff[c] = $signed({1'b0, smp_reg[c]}) - $signed({1'b0, ech[c]});
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
            sq_reg[c] <= 24'(diff[c] * diff[c]);
        lab2_reg  <= rd_reg.label;
        slot2_reg <= slot1_reg;
        sum_reg   <= DIST_W'(sq_reg[0]) + DIST_W'(sq_reg[1]) + DIST_W'(sq_reg[2]);
        lab3_reg  <= lab2_reg;
        slot3_reg <= slot2_reg;
    end

    assign chain[0] = '{valid: v3_reg, label: lab3_reg, slot: slot3_reg, distance: sum_reg};

    for (genvar g = 0; g < NEIGHBORS; g++)
    begin : g_cell
        kcc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .clear    (clear_cells),
            .cand_in  (chain[g]),
            .cand_out (chain[g+1]),
            .held     (held[g])
        );
    end

    // vote over the held neighbors
    always_comb
    begin
        red_cnt   = '0;
        green_cnt = '0;
        for (int k = 0; k < NEIGHBORS; k++)
        begin
            if (held[k].valid)
            begin
                if (held[k].label)
                    green_cnt = green_cnt + VOTE_W'(1);
                else
                    red_cnt = red_cnt + VOTE_W'(1);
            end
        end
    end

    assign best = held[0].valid ? held[0].distance : DIST_MAX;
    assign cls  = (red_cnt > green_cnt) ? CLASS_RED :
                  ((green_cnt > red_cnt) ? CLASS_GREEN : CLASS_NEITHER);

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            dist_reg <= best;
            if (!held[0].valid || (best > limit_reg))
            begin
                class_reg <= CLASS_NEITHER;
                red_reg   <= '0;
                green_reg <= '0;
            end
            else
            begin
                class_reg <= cls;
                red_reg   <= red_cnt;
                green_reg <= green_cnt;
            end
        end
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.colour_class     = class_reg;
    assign out_ch.nearest_distance = dist_reg;
    assign out_ch.red_votes        = red_reg;
    assign out_ch.green_votes      = green_reg;

endmodule

>>> hdl/kcc_checker.sv
// Port-level checks for the classifier, bound to the top level.
module kcc_checker
    import kcc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               in_func,
    input logic               out_valid,
    input logic               out_ready,
    input logic [CLASS_W-1:0] out_class,
    input logic [VOTE_W-1:0]  out_red,
    input logic [VOTE_W-1:0]  out_green
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_class))
        else $error("stalled result beat changed");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_func == FUNC_CLASSIFY) |=> !in_ready)
        else $error("input taken while classifying");

    a_red: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_class == CLASS_RED) |-> out_red > out_green)
        else $error("red class without red majority");

    a_green: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_class == CLASS_GREEN) |-> out_green > out_red)
        else $error("green class without green majority");

endmodule

bind knn_color_classifier_core kcc_checker u_kcc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_func   (in_ch.func),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_class (out_ch.colour_class),
    .out_red   (out_ch.red_votes),
    .out_green (out_ch.green_votes)
);
